### rtl/ipv4_lpm_pkg.sv
package ipv4_lpm_pkg;

   localparam int ROUTE_ENTRIES_DEFAULT = 64;

   localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

   localparam logic [3:0] HDR_SKIP_POS = 4'd2;
   localparam logic [3:0] HDR_TTL_POS  = 4'd2;
   localparam logic [3:0] HDR_DEST_POS = 4'd4;
   localparam logic [3:0] HDR_POS_MAX  = 4'd15;

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_ADD    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_LOCAL    = 2'd0,
      VERDICT_FORWARD  = 2'd1,
      VERDICT_TTL_DROP = 2'd2,
      VERDICT_NO_ROUTE = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1
   } state_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic [31:0] hop;
   } route_entry_type;

   // One's complement add of a 16-bit half with end-around carry.
   function automatic logic [15:0] fold_add(input logic [15:0] sum, input logic [15:0] half);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, sum} + {1'b0, half};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

   // Network mask for a prefix length; length zero gives an empty mask.
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) begin
         m = 32'd0;
      end else if (len >= MAX_PREFIX_LEN) begin
         m = 32'hFFFF_FFFF;
      end else begin
         m = ~(32'hFFFF_FFFF >> len);
      end
      return m;
   endfunction

endpackage

### rtl/ipv4_forward_lpm_core.sv
// A header word that is not last, a route add or a clear is taken while idle; busy stays low.
// Last header word: local or TTL verdicts show on rsp_valid the next cycle; otherwise the route
// table walk holds busy high, and the result strobes in the cycle after the walk ends.
// The walk reads one table entry per cycle from the route memory, which has a separate write port.
// Reset clears the route count, the packet state and local_address; no memory clearing pass.
// The receiver cannot stall: each result is on rsp_* for exactly one cycle with rsp_valid.
module ipv4_forward_lpm_core
   import ipv4_lpm_pkg::*;
#(
   parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // command side
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_header_word,
   input  logic        req_last_word,
   input  logic [31:0] req_route_prefix,
   input  logic [5:0]  req_prefix_length,
   input  logic [31:0] req_route_next_hop,
   // result side
   output logic        rsp_valid,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_next_hop,
   output logic [7:0]  rsp_new_ttl,
   output logic [15:0] rsp_new_checksum,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_local_address
);

   localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CW = $clog2(ROUTE_ENTRIES + 1);
   localparam logic [CW-1:0] ENTRIES_C = CW'(ROUTE_ENTRIES);

   // Control state
   state_type       state_ff, state_in;
   logic [CW-1:0]   route_count_ff, route_count_in;
   logic [CW-1:0]   scan_addr_ff, scan_addr_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [31:0]     local_address_ff;

   // Packet state, returns to zero after every last word
   logic [3:0]      word_pos_ff, word_pos_in;
   logic [15:0]     running_sum_ff, running_sum_in;
   logic [7:0]      held_ttl_ff, held_ttl_in;
   logic [31:0]     held_dest_ff, held_dest_in;
   logic [3:0]      held_ihl_ff, held_ihl_in;

   // Lookup operands and best match so far
   logic [31:0]     fin_dest_ff, fin_dest_in;
   logic [7:0]      fin_ttl_ff, fin_ttl_in;
   logic [15:0]     fin_csum_ff, fin_csum_in;
   logic [5:0]      best_len_ff, best_len_in;
   logic [31:0]     best_hop_ff, best_hop_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   verdict_type     rsp_verdict_ff, rsp_verdict_in;
   logic [31:0]     rsp_next_hop_ff, rsp_next_hop_in;
   logic [7:0]      rsp_new_ttl_ff, rsp_new_ttl_in;
   logic [15:0]     rsp_new_checksum_ff, rsp_new_checksum_in;

   // Route memory
   route_entry_type route_mem [ROUTE_ENTRIES];
   route_entry_type rd_data_ff;
   route_entry_type wr_entry;
   logic            wr_en;

   // Combinational helpers
   logic            accept;
   op_type          op;
   logic [3:0]      ihl_now;
   logic [7:0]      ttl_now;
   logic [31:0]     dest_now;
   logic [15:0]     hi_half;
   logic [15:0]     sum_hi;
   logic [15:0]     sum_now;
   logic            issue;
   logic            hit;
   logic [5:0]      add_len;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign op        = op_type'(req_operation);
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_next_hop     = rsp_next_hop_ff;
   assign rsp_new_ttl      = rsp_new_ttl_ff;
   assign rsp_new_checksum = rsp_new_checksum_ff;

   // Header word view: fold this word into the held packet state
   always_comb begin
      ihl_now  = (word_pos_ff == 4'd0) ? req_header_word[27:24] : held_ihl_ff;
      ttl_now  = (word_pos_ff == HDR_TTL_POS) ? req_header_word[31:24] : held_ttl_ff;
      dest_now = (word_pos_ff == HDR_DEST_POS) ? req_header_word : held_dest_ff;
      // TTL byte counts as TTL minus one in the new checksum
      hi_half  = (word_pos_ff == HDR_TTL_POS) ?
                 {req_header_word[31:24] - 8'd1, req_header_word[23:16]} :
                 req_header_word[31:16];
      sum_hi   = fold_add(running_sum_ff, hi_half);
      sum_now  = running_sum_ff;
      if ((word_pos_ff < ihl_now) && (word_pos_ff < HDR_POS_MAX)) begin
         // skip the old checksum half of word two
         sum_now = (word_pos_ff != HDR_SKIP_POS) ?
                   fold_add(sum_hi, req_header_word[15:0]) : sum_hi;
      end
   end

   // Table walk: issue one read per cycle, compare each entry in the cycle after its read
   assign issue = (state_ff == ST_SCAN) && (scan_addr_ff < route_count_ff);
   assign hit   = rd_valid_ff && (rd_data_ff.len > best_len_ff) &&
                  (rd_data_ff.prefix == (fin_dest_ff & prefix_mask(rd_data_ff.len)));

   assign add_len = (req_prefix_length > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : req_prefix_length;

   // Next state and outputs
   always_comb begin
      state_in            = state_ff;
      route_count_in      = route_count_ff;
      scan_addr_in        = scan_addr_ff;
      rd_valid_in         = issue;
      word_pos_in         = word_pos_ff;
      running_sum_in      = running_sum_ff;
      held_ttl_in         = held_ttl_ff;
      held_dest_in        = held_dest_ff;
      held_ihl_in         = held_ihl_ff;
      fin_dest_in         = fin_dest_ff;
      fin_ttl_in          = fin_ttl_ff;
      fin_csum_in         = fin_csum_ff;
      best_len_in         = best_len_ff;
      best_hop_in         = best_hop_ff;
      rsp_valid_in        = 1'b0;
      rsp_verdict_in      = rsp_verdict_ff;
      rsp_next_hop_in     = rsp_next_hop_ff;
      rsp_new_ttl_in      = rsp_new_ttl_ff;
      rsp_new_checksum_in = rsp_new_checksum_ff;
      wr_en               = 1'b0;
      wr_entry.prefix     = req_route_prefix;
      wr_entry.len        = add_len;
      wr_entry.hop        = req_route_next_hop;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_ADD: begin
                     // drop adds to a full table
                     if (route_count_ff < ENTRIES_C) begin
                        wr_en          = 1'b1;
                        route_count_in = route_count_ff + CW'(1);
                     end
                  end
                  OP_CLEAR: begin
                     route_count_in = '0;
                  end
                  OP_HEADER: begin
                     word_pos_in    = (word_pos_ff < HDR_POS_MAX) ? word_pos_ff + 4'd1 :
                                                                    word_pos_ff;
                     running_sum_in = sum_now;
                     held_ttl_in    = ttl_now;
                     held_dest_in   = dest_now;
                     held_ihl_in    = ihl_now;
                     if (req_last_word) begin
                        word_pos_in    = '0;
                        running_sum_in = '0;
                        held_ttl_in    = '0;
                        held_dest_in   = '0;
                        held_ihl_in    = '0;
                        fin_dest_in    = dest_now;
                        fin_ttl_in     = ttl_now;
                        fin_csum_in    = ~sum_now;
                        if (dest_now == local_address_ff) begin
                           rsp_valid_in        = 1'b1;
                           rsp_verdict_in      = VERDICT_LOCAL;
                           rsp_next_hop_in     = '0;
                           rsp_new_ttl_in      = '0;
                           rsp_new_checksum_in = '0;
                        end else if (ttl_now == 8'd0) begin
                           rsp_valid_in        = 1'b1;
                           rsp_verdict_in      = VERDICT_TTL_DROP;
                           rsp_next_hop_in     = '0;
                           rsp_new_ttl_in      = '0;
                           rsp_new_checksum_in = '0;
                        end else begin
                           state_in     = ST_SCAN;
                           scan_addr_in = '0;
                           best_len_in  = '0;
                           best_hop_in  = '0;
                        end
                     end
                  end
                  default: begin
                     // unused code: ignore
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_addr_in = scan_addr_ff + CW'(1);
            end
            if (hit) begin
               best_len_in = rd_data_ff.len;
               best_hop_in = rd_data_ff.hop;
            end
            if (!issue && !rd_valid_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (best_len_ff != 6'd0) begin
                  rsp_verdict_in      = VERDICT_FORWARD;
                  rsp_next_hop_in     = best_hop_ff;
                  rsp_new_ttl_in      = fin_ttl_ff - 8'd1;
                  rsp_new_checksum_in = fin_csum_ff;
               end else begin
                  rsp_verdict_in      = VERDICT_NO_ROUTE;
                  rsp_next_hop_in     = '0;
                  rsp_new_ttl_in      = '0;
                  rsp_new_checksum_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         route_count_ff   <= '0;
         scan_addr_ff     <= '0;
         rd_valid_ff      <= 1'b0;
         local_address_ff <= '0;
         word_pos_ff      <= '0;
         running_sum_ff   <= '0;
         held_ttl_ff      <= '0;
         held_dest_ff     <= '0;
         held_ihl_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         route_count_ff <= route_count_in;
         scan_addr_ff   <= scan_addr_in;
         rd_valid_ff    <= rd_valid_in;
         word_pos_ff    <= word_pos_in;
         running_sum_ff <= running_sum_in;
         held_ttl_ff    <= held_ttl_in;
         held_dest_ff   <= held_dest_in;
         held_ihl_ff    <= held_ihl_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            local_address_ff <= csr_local_address;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fin_dest_ff         <= fin_dest_in;
      fin_ttl_ff          <= fin_ttl_in;
      fin_csum_ff         <= fin_csum_in;
      best_len_ff         <= best_len_in;
      best_hop_ff         <= best_hop_in;
      rsp_verdict_ff      <= rsp_verdict_in;
      rsp_next_hop_ff     <= rsp_next_hop_in;
      rsp_new_ttl_ff      <= rsp_new_ttl_in;
      rsp_new_checksum_ff <= rsp_new_checksum_in;
   end

   // Route memory: write at the fill count, registered read at the walk address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[route_count_ff[AW-1:0]] <= wr_entry;
      end
      rd_data_ff <= route_mem[scan_addr_ff[AW-1:0]];
   end

   // Assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      route_count_ff <= ENTRIES_C)
      else $error("route count beyond table size");

   a_scan_addr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_addr_ff <= route_count_ff))
      else $error("walk address beyond route count");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_SCAN))
      else $error("table read data outside of walk");

   a_drop_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_verdict_ff != VERDICT_FORWARD)) |->
      ((rsp_new_ttl_ff == 8'd0) && (rsp_new_checksum_ff == 16'd0) &&
       (rsp_next_hop_ff == 32'd0)))
      else $error("non-forward result carries forwarding fields");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (route_count_ff == $past(route_count_ff)))
      else $error("route table changed during walk");

endmodule

### dv/ipv4_forward_lpm_core_test.sv
module ipv4_forward_lpm_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ipv4_lpm_pkg::*;

   localparam int ROUTE_DEPTH    = ROUTE_ENTRIES_DEFAULT;
   localparam int RESET_CYCLES   = 12;
   // Longest route walk plus result strobe, with margin; covers work that yields no result.
   localparam int SETTLE_CYCLES  = ROUTE_DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int POOL_SIZE      = 8;
   localparam int PHASE_ITEMS    = 390;
   localparam int PHASE_COUNT    = 5;

   // One command transaction as presented on the req_* ports.
   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic        last;
      logic [31:0] prefix;
      logic [5:0]  plen;
      logic [31:0] hop;
   } route_cmd_type;

   // One forwarding decision as seen on the rsp_* ports.
   typedef struct packed {
      verdict_type verdict;
      logic [31:0] hop;
      logic [7:0]  ttl;
      logic [15:0] csum;
   } forward_decision_type;

   logic        clock;
   logic        reset              = 1'b1;
   logic        start              = 1'b0;
   logic        busy;
   logic [1:0]  req_operation      = OP_HEADER;
   logic [31:0] req_header_word    = 32'd0;
   logic        req_last_word      = 1'b0;
   logic [31:0] req_route_prefix   = 32'd0;
   logic [5:0]  req_prefix_length  = 6'd0;
   logic [31:0] req_route_next_hop = 32'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_next_hop;
   logic [7:0]  rsp_new_ttl;
   logic [15:0] rsp_new_checksum;
   logic        csr_valid          = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_local_address  = 32'd0;

   ipv4_forward_lpm_core #(
      .ROUTE_ENTRIES(ROUTE_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_header_word    (req_header_word),
      .req_last_word      (req_last_word),
      .req_route_prefix   (req_route_prefix),
      .req_prefix_length  (req_prefix_length),
      .req_route_next_hop (req_route_next_hop),
      .rsp_valid          (rsp_valid),
      .rsp_verdict        (rsp_verdict),
      .rsp_next_hop       (rsp_next_hop),
      .rsp_new_ttl        (rsp_new_ttl),
      .rsp_new_checksum   (rsp_new_checksum),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_local_address  (csr_local_address)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stimulus bookkeeping: the backlog feeds the driver; the counters let the
   // sequence tell when every queued transaction has gone through.
   route_cmd_type        cmd_backlog[$];
   forward_decision_type pending_decisions[$];
   logic [31:0]          addr_pool [POOL_SIZE];
   int                   total_queued   = 0;
   int                   accepted_total = 0;
   int                   mismatch_count = 0;
   int                   gap_left       = 0;
   int                   quiet_cycles   = 0;
   logic                 taken          = 1'b0;
   logic                 no_idle        = 1'b0;

   // Forwarding model state: register, route table and the packet in flight.
   logic [31:0] model_local;
   logic [31:0] tbl_prefix [ROUTE_DEPTH];
   logic [5:0]  tbl_len    [ROUTE_DEPTH];
   logic [31:0] tbl_hop    [ROUTE_DEPTH];
   int          tbl_count;
   logic [3:0]  hdr_pos;
   logic [15:0] hdr_sum;
   logic [7:0]  hdr_ttl;
   logic [31:0] hdr_dest;
   logic [3:0]  hdr_ihl;

   // One's complement addition: wrap the carry out back into bit 0.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[15:0] + {15'd0, total[16]};
   endfunction

   function automatic logic [31:0] network_mask(input logic [5:0] len);
      if (len == 6'd0) return 32'd0;
      if (len >= 6'd32) return 32'hFFFF_FFFF;
      return 32'hFFFF_FFFF << (6'd32 - len);
   endfunction

   task automatic drop_packet_state();
      hdr_pos  = 4'd0;
      hdr_sum  = 16'd0;
      hdr_ttl  = 8'd0;
      hdr_dest = 32'd0;
      hdr_ihl  = 4'd0;
   endtask

   // Advance the forwarding model by one accepted transaction; queue the
   // decision when it closes a packet.
   task automatic advance_forwarding_model(input route_cmd_type cmd);
      logic [5:0]           stored_len;
      logic [5:0]           best_len;
      logic [15:0]          hi_half;
      forward_decision_type decision;
      case (cmd.op)
         OP_ADD: begin
            stored_len = (cmd.plen > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : cmd.plen;
            // Drop the add silently once the table is full.
            if (tbl_count < ROUTE_DEPTH) begin
               tbl_prefix[tbl_count] = cmd.prefix;
               tbl_len[tbl_count]    = stored_len;
               tbl_hop[tbl_count]    = cmd.hop;
               tbl_count++;
            end
         end
         OP_CLEAR: begin
            tbl_count = 0;
         end
         OP_HEADER: begin
            hi_half = cmd.word[31:16];
            if (hdr_pos == 4'd0) hdr_ihl = cmd.word[27:24];
            if (hdr_pos == HDR_TTL_POS) begin
               // Sum the TTL as it leaves the node, already decremented.
               hdr_ttl = cmd.word[31:24];
               hi_half = {cmd.word[31:24] - 8'd1, cmd.word[23:16]};
            end
            if (hdr_pos == HDR_DEST_POS) hdr_dest = cmd.word;
            if (hdr_pos < hdr_ihl && hdr_pos < HDR_POS_MAX) begin
               hdr_sum = ones_add(hdr_sum, hi_half);
               // Skip the old checksum half of word two.
               if (hdr_pos != HDR_SKIP_POS) hdr_sum = ones_add(hdr_sum, cmd.word[15:0]);
            end
            // Hold the position at fifteen for overlong headers.
            if (hdr_pos < HDR_POS_MAX) hdr_pos++;
            if (cmd.last) begin
               decision = '{verdict: VERDICT_NO_ROUTE, hop: 32'd0, ttl: 8'd0, csum: 16'd0};
               if (hdr_dest == model_local) begin
                  decision.verdict = VERDICT_LOCAL;
               end else if (hdr_ttl == 8'd0) begin
                  decision.verdict = VERDICT_TTL_DROP;
               end else begin
                  // Longest match wins; strict compare keeps the first entry on a tie
                  // and keeps a zero-length prefix from ever matching.
                  best_len = 6'd0;
                  for (int i = 0; i < tbl_count; i++) begin
                     if (tbl_len[i] > best_len &&
                         tbl_prefix[i] == (hdr_dest & network_mask(tbl_len[i]))) begin
                        best_len     = tbl_len[i];
                        decision.hop = tbl_hop[i];
                     end
                  end
                  if (best_len != 6'd0) begin
                     decision.verdict = VERDICT_FORWARD;
                     decision.ttl     = hdr_ttl - 8'd1;
                     decision.csum    = ~hdr_sum;
                  end
               end
               pending_decisions = {pending_decisions, decision};
               drop_packet_state();
            end
         end
         default: begin
         end
      endcase
   endtask

   // Stimulus helpers.
   task automatic push_command(input route_cmd_type cmd);
      total_queued++;
      cmd_backlog = {cmd_backlog, cmd};
   endtask

   // Fill the fields an operation ignores with noise so every bit toggles.
   function automatic route_cmd_type random_command(input op_type op);
      route_cmd_type cmd;
      cmd.op     = op;
      cmd.word   = $urandom();
      cmd.last   = 1'($urandom_range(0, 1));
      cmd.prefix = $urandom();
      cmd.plen   = 6'($urandom_range(0, 63));
      cmd.hop    = $urandom();
      return cmd;
   endfunction

   task automatic queue_simple(input op_type op);
      push_command(random_command(op));
   endtask

   task automatic queue_header(input logic [31:0] word, input logic last);
      route_cmd_type cmd;
      cmd      = random_command(OP_HEADER);
      cmd.word = word;
      cmd.last = last;
      push_command(cmd);
   endtask

   task automatic queue_route(input logic [31:0] prefix, input logic [5:0] len,
                              input logic [31:0] hop);
      route_cmd_type cmd;
      cmd        = random_command(OP_ADD);
      cmd.prefix = prefix;
      cmd.plen   = len;
      cmd.hop    = hop;
      push_command(cmd);
   endtask

   // Draw routes around the address pool so lookups hit at assorted lengths.
   task automatic queue_random_route();
      logic [31:0] base;
      logic [5:0]  len;
      int          pick;
      base = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         len = 6'd0;
      end else if (pick < 10) begin
         len = 6'($urandom_range(33, 63));
      end else begin
         len = 6'($urandom_range(1, 32));
      end
      // Now and then a random prefix that is not masked to its length.
      if ($urandom_range(0, 19) == 0) begin
         base = $urandom();
      end else begin
         base = base & network_mask(len);
      end
      queue_route(base, len, $urandom());
   endtask

   // Write local_address over the configuration channel; hold valid until ready.
   task automatic write_local(input logic [31:0] value);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_local_address <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every queued transaction is taken and every decision is back,
   // then let a full route walk pass.
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_total != total_queued || busy || pending_decisions.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: present the next transaction at the falling edge, hold it while
   // busy blocks it, and insert a random gap after each accepted one.
   always @(negedge clock) begin : drive_requests
      route_cmd_type next_cmd;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // hold the transaction until the block takes it
      end else if (gap_left != 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
         next_cmd = cmd_backlog.pop_front();
         start              <= 1'b1;
         req_operation      <= next_cmd.op;
         req_header_word    <= next_cmd.word;
         req_last_word      <= next_cmd.last;
         req_route_prefix   <= next_cmd.prefix;
         req_prefix_length  <= next_cmd.plen;
         req_route_next_hop <= next_cmd.hop;
         // Mostly back to back, else short gaps or a few long ones, and occasional stretches without any.
         if (no_idle) begin
            gap_left <= 0;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap_left <= 0;
               11, 12, 13, 14, 15, 16:           gap_left <= $urandom_range(1, 3);
               17, 18:                           gap_left <= $urandom_range(4, 12);
               default:                          gap_left <= $urandom_range(20, 60);
            endcase
         end
         if ($urandom_range(0, 149) == 0) no_idle <= !no_idle;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: sample at the rising edge, check each result strobe against the
   // oldest predicted decision, then advance the model with the accepted transaction.
   always @(posedge clock) begin : check_results
      forward_decision_type want;
      route_cmd_type        seen;
      if (reset) begin
         taken       <= 1'b0;
         model_local  = 32'd0;
         tbl_count    = 0;
         drop_packet_state();
      end else begin
         taken <= start && !busy;
         if (rsp_valid) begin
            if (pending_decisions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected decision verdict %0d hop %h ttl %0d csum %h",
                           $time, rsp_verdict, rsp_next_hop, rsp_new_ttl, rsp_new_checksum);
               end
            end else begin
               want = pending_decisions.pop_front();
               if (rsp_verdict !== want.verdict || rsp_next_hop !== want.hop ||
                   rsp_new_ttl !== want.ttl || rsp_new_checksum !== want.csum) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: decision mismatch: expected verdict %0d hop %h ttl %0d csum %h",
                              $time, want.verdict, want.hop, want.ttl, want.csum);
                     $display("%0t:                    actual verdict %0d hop %h ttl %0d csum %h",
                              $time, rsp_verdict, rsp_next_hop, rsp_new_ttl, rsp_new_checksum);
                  end
               end
            end
         end
         if (start && !busy) begin
            seen = '{op: op_type'(req_operation), word: req_header_word, last: req_last_word,
                     prefix: req_route_prefix, plen: req_prefix_length,
                     hop: req_route_next_hop};
            advance_forwarding_model(seen);
            accepted_total <= accepted_total + 1;
         end
         // The register takes its new value after this edge's transaction.
         if (csr_valid && csr_ready) model_local = csr_local_address;
      end
   end

   // Watchdog: end the run when no transaction moves on any port for too long.
   always @(posedge clock) begin : watchdog
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ipv4_forward_lpm_core_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_sequence
      logic [31:0] phase_values [PHASE_COUNT];
      logic [31:0] w;
      logic [3:0]  ihl;
      int          phase_start;
      int          pick;
      int          words;
      for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = $urandom();
      // Sweep local_address across both extremes, random values and a pool neighbor.
      phase_values[0] = 32'h0000_0000;
      phase_values[1] = 32'hFFFF_FFFF;
      phase_values[2] = $urandom();
      phase_values[3] = addr_pool[1] ^ 32'h0000_00FF;
      phase_values[4] = $urandom();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      write_local(32'hC0A8_0001);
      queue_simple(OP_NONE);
      // One-word packet: destination and TTL never seen, so TTL expired.
      queue_header(32'h4500_0000, 1'b1);
      queue_route(32'h0000_0000, 6'd0, 32'hDEAD_0000);
      queue_route(32'h0A00_0000, 6'd8, 32'h1111_1111);
      queue_route(32'h0A01_0000, 6'd16, 32'h2222_2222);
      queue_route(32'h0A01_0000, 6'd16, 32'h3333_3333);
      queue_route(32'h0A01_0203, 6'd63, 32'hFFFF_FFFF);
      // TTL of one, all-ones halves for carry wrap, host route beats the /16s.
      queue_header(32'h4500_FFFF, 1'b0);
      queue_header(32'hFFFF_FFFF, 1'b0);
      queue_header(32'h0106_FFFF, 1'b0);
      queue_header(32'h0000_0000, 1'b0);
      queue_header(32'h0A01_0203, 1'b1);
      // Header length four: sum stops early, destination still taken; first /16 wins.
      queue_header(32'h44FF_FFFF, 1'b0);
      queue_header(32'hFFFF_FFFF, 1'b0);
      queue_header(32'hFF11_0000, 1'b0);
      queue_header(32'hFFFF_FFFF, 1'b0);
      queue_header(32'h0A01_0909, 1'b1);
      // Addressed to this node.
      queue_header(32'h4500_0014, 1'b0);
      queue_header(32'h1234_4000, 1'b0);
      queue_header(32'h4006_B1E6, 1'b0);
      queue_header(32'hC0A8_0002, 1'b0);
      queue_header(32'hC0A8_0001, 1'b1);
      // Empty table after a clear: no route.
      queue_simple(OP_CLEAR);
      queue_header(32'h4500_001C, 1'b0);
      queue_header(32'h0000_0000, 1'b0);
      queue_header(32'h4011_0000, 1'b1);
      wait_idle();

      // Random part, one local_address setting per phase.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_local(phase_values[p]);
         phase_start = total_queued;
         while (total_queued - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 999);
            if (pick < 620) begin
               // Packet with random content, mostly well-formed; sizes skewed toward five words.
               pick = $urandom_range(0, 99);
               if (pick < 65) begin
                  words = 5;
               end else if (pick < 80) begin
                  words = $urandom_range(6, 15);
               end else if (pick < 88) begin
                  words = $urandom_range(16, 19);
               end else begin
                  words = $urandom_range(1, 4);
               end
               if ($urandom_range(0, 4) == 0) begin
                  ihl = 4'($urandom_range(0, 15));
               end else if (words > 15) begin
                  ihl = 4'd15;
               end else if (words < 5) begin
                  ihl = 4'd5;
               end else begin
                  ihl = 4'(words);
               end
               for (int i = 0; i < words; i++) begin
                  w = $urandom();
                  if (i == 0 && $urandom_range(0, 9) != 0) w[31:24] = {4'h4, ihl};
                  if (i == 2) begin
                     pick = $urandom_range(0, 99);
                     if (pick < 10) begin
                        w[31:24] = 8'h00;
                     end else if (pick < 15) begin
                        w[31:24] = 8'h01;
                     end else if (pick < 20) begin
                        w[31:24] = 8'hFF;
                     end
                  end
                  if (i == 4) begin
                     pick = $urandom_range(0, 99);
                     if (pick < 8) begin
                        w = phase_values[p];
                     end else if (pick >= 13) begin
                        w = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^
                            ($urandom() >> $urandom_range(0, 32));
                     end
                  end
                  // Change the table in the middle of a packet now and then.
                  if (i > 0 && $urandom_range(0, 39) == 0) begin
                     pick = $urandom_range(0, 9);
                     if (pick < 7) begin
                        queue_random_route();
                     end else if (pick < 9) begin
                        queue_simple(OP_NONE);
                     end else begin
                        queue_simple(OP_CLEAR);
                     end
                  end
                  queue_header(w, i == words - 1);
               end
            end else if (pick < 900) begin
               queue_random_route();
            end else if (pick < 930) begin
               // Truncated packet: its words run into the next one.
               repeat ($urandom_range(1, 3)) queue_header($urandom(), 1'b0);
            end else if (pick < 950) begin
               queue_simple(OP_NONE);
            end else if (pick < 965) begin
               queue_simple(OP_CLEAR);
            end else if (pick < 975) begin
               // Fill the table and push past full.
               repeat (ROUTE_DEPTH + 4) queue_random_route();
            end else begin
               queue_header($urandom(), 1'($urandom_range(0, 1)));
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("ipv4_forward_lpm_core_test: PASS");
      end else begin
         $display("ipv4_forward_lpm_core_test: FAIL");
      end
      $finish;
   end

endmodule
